FILE: rtl/m4inv_pkg.sv
// shared constants, types and an index function for the 4x4 matrix inverse core
package m4inv_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned ElemW  = 32;
  localparam int unsigned DetW   = 160;
  localparam int unsigned DivW   = 192;
  localparam int unsigned DivCntW = 8;

  typedef enum logic [3:0] {
    MulOpSet = 4'b0001,
    MulOpAdd = 4'b0010,
    MulOpSub = 4'b0100,
    MulOpNop = 4'b1000
  } mul_op_e;

  typedef struct packed {
    logic      start;
    logic      busy;
    logic      done;
  } div_ctrl_t;

  // row or column index of the 3x3 minor that removes index skip, at position pos
  function automatic logic [1:0] minor_idx(input logic [1:0] skip, input logic [1:0] pos);
    logic [1:0] r;
    r = (pos < skip) ? pos : 2'(pos + 2'd1);
    return r;
  endfunction

endpackage

FILE: rtl/matrix4x4_inverse_core.sv
// top level: element loader, cofactor sequencer over a shared mac, divider, output stage
// Loads 16 signed Q16.16 elements (one per accepted transaction, row-major); the
// sixteenth starts the computation and element_stall_o stays high until all 16
// results have been taken. Each cofactor is built from three 2x2 minors, each two
// multiplies through one shared 32x32 multiplier and a 160-bit accumulator, then
// weighted by a row element with a 32-step shift-add; the determinant is then formed
// the same way from the first-row cofactors. Each output then needs one bit-serial
// division (skipped when the determinant is zero, which marks the result singular).
// Results are held in an output register, so the downstream side may stall freely.
module matrix4x4_inverse_core #(
  parameter int unsigned FRAC_BITS = m4inv_pkg::FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        element_valid_i,
  output logic        element_stall_o,
  input  logic signed [31:0] element_i,
  output logic        inv_valid_o,
  input  logic        inv_stall_i,
  output logic signed [31:0] inv_element_o,
  output logic        singular_o,
  output logic        last_o
);
  typedef enum logic [6:0] {
    StLoad  = 7'b0000001,
    StMinor = 7'b0000010,
    StWait  = 7'b0000100,
    StCof   = 7'b0001000,
    StDet   = 7'b0010000,
    StDiv   = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  localparam int unsigned DW = m4inv_pkg::DetW;

  state_e state_q;
  logic [31:0]   mat_q [16];
  logic [3:0]    cnt_q;
  logic [3:0]    cof_q;
  logic [2:0]    step_q;
  logic [1:0]    wait_q;
  logic signed [DW-1:0] cofs_q [16];
  logic signed [DW-1:0] minor_q;
  logic signed [DW-1:0] det_q;
  logic [3:0]    oidx_q;

  logic               mv;
  m4inv_pkg::mul_op_e mop;
  logic signed [31:0] ma, mb;
  logic signed [DW-1:0] acc;
  logic               dstart, dbusy;
  logic [m4inv_pkg::DivW-1:0] quo;
  logic [m4inv_pkg::DivW-1:0] num;
  logic [DW-1:0]      dmag;
  logic signed [DW-1:0] cur;
  logic               qneg;
  logic               accept;

  m4inv_mac u_mac (.clk_i, .rst_ni, .mul_valid_i(mv), .op_i(mop), .a_i(ma), .b_i(mb),
                   .acc_o(acc));
  m4inv_div u_div (.clk_i, .rst_ni, .start_i(dstart), .num_i(num), .den_i(dmag),
                   .busy_o(dbusy), .quo_o(quo));

  assign accept = element_valid_i && !element_stall_o;
  assign element_stall_o = (state_q != StLoad);

  // minor operands: cofactor (row i, col j); minor entry (r,c) from 3x3 submatrix
  logic [1:0] ci, cj, rr0, rr1, rr2, cc0, cc1, cc2, ra, rb, kb, kc;
  always_comb begin
    ci  = cof_q[3:2];
    cj  = cof_q[1:0];
    rr0 = m4inv_pkg::minor_idx(ci, 2'd0);
    rr1 = m4inv_pkg::minor_idx(ci, 2'd1);
    rr2 = m4inv_pkg::minor_idx(ci, 2'd2);
    cc0 = m4inv_pkg::minor_idx(cj, 2'd0);
    cc1 = m4inv_pkg::minor_idx(cj, 2'd1);
    cc2 = m4inv_pkg::minor_idx(cj, 2'd2);
    // term k (0..2) uses b[0][k] times det of rows 1,2 excluding column k
    case (step_q[2:1])
      2'd0:    begin kb = cc1; kc = cc2; end
      2'd1:    begin kb = cc0; kc = cc2; end
      default: begin kb = cc0; kc = cc1; end
    endcase
    ra = rr1;
    rb = rr2;
  end

  // sequencer driving the shared mac
  always_comb begin
    mv = 1'b0;
    mop = m4inv_pkg::MulOpNop;
    ma = '0;
    mb = '0;
    if (state_q == StMinor) begin
      mv = 1'b1;
      if (!step_q[0]) begin
        mop = m4inv_pkg::MulOpSet;
        ma = mat_q[{ra, kb}];
        mb = mat_q[{rb, kc}];
      end else begin
        mop = m4inv_pkg::MulOpSub;
        ma = mat_q[{ra, kc}];
        mb = mat_q[{rb, kb}];
      end
    end
  end

  // sign of the quotient for output element oidx: cofactor (c,r)
  assign cur  = cofs_q[{oidx_q[1:0], oidx_q[3:2]}];
  assign qneg = cur[DW-1] ^ det_q[DW-1];
  assign dmag = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
  always_comb begin
    logic [DW-1:0] cm;
    cm  = cur[DW-1] ? DW'(-cur) : DW'(cur);
    num = m4inv_pkg::DivW'(cm) << (2 * FRAC_BITS);
  end

  // term of the minor just finished: step has already moved one term ahead
  logic [1:0] tk;
  assign tk = step_q[2:1] - 2'd1;

  // weighting of a 2x2 minor by its row element is a wide x 32 product, done
  // as a serial shift-add over the element bits below
  logic [5:0]  sh_q;
  logic signed [DW-1:0] part_q;
  logic signed [DW-1:0] sum_q;
  logic [31:0] w_q;
  logic signed [31:0] wel;

  always_comb begin
    case (tk)
      2'd0:    wel = mat_q[{rr0, cc0}];
      2'd1:    wel = mat_q[{rr0, cc1}];
      default: wel = mat_q[{rr0, cc2}];
    endcase
  end

  // main control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
      cof_q   <= '0;
      step_q  <= '0;
      wait_q  <= '0;
      oidx_q  <= '0;
      sh_q    <= '0;
      inv_valid_o <= 1'b0;
    end else begin
      case (state_q)
        StLoad: begin
          if (accept) begin
            cnt_q <= cnt_q + 4'd1;
            if (cnt_q == 4'd15) begin
              state_q <= StMinor;
              cof_q   <= '0;
              step_q  <= '0;
            end
          end
        end
        StMinor: begin
          step_q <= step_q + 3'd1;
          if (step_q[0]) begin
            state_q <= StWait;
            wait_q  <= 2'd1;
          end
        end
        StWait: begin
          wait_q <= wait_q - 2'd1;
          if (wait_q == '0) begin
            state_q <= StCof;
            sh_q    <= '0;
          end
        end
        StCof: begin
          // serial multiply: 32 shift-add steps of minor times element
          if (sh_q == 6'd31) begin
            sh_q <= '0;
            if (step_q == 3'd6) begin
              step_q <= '0;
              cof_q  <= cof_q + 4'd1;
              if (cof_q == 4'd15) state_q <= StDet;
              else                state_q <= StMinor;
            end else begin
              state_q <= StMinor;
            end
          end else begin
            sh_q <= sh_q + 6'd1;
          end
        end
        StDet: begin
          if (sh_q == 6'd31) begin
            step_q <= step_q + 3'd1;
            sh_q   <= '0;
            if (step_q == 3'd3) begin
              state_q <= StDiv;
              oidx_q  <= '0;
              wait_q  <= 2'd0;
            end
          end else begin
            sh_q <= sh_q + 6'd1;
          end
        end
        StDiv: begin
          if (!dbusy && wait_q == 2'd1) begin
            state_q <= StOut;
            inv_valid_o <= 1'b1;
          end else if (wait_q == 2'd0) begin
            wait_q <= 2'd1;
          end
        end
        StOut: begin
          if (!inv_stall_i) begin
            inv_valid_o <= 1'b0;
            oidx_q <= oidx_q + 4'd1;
            wait_q <= 2'd0;
            if (oidx_q == 4'd15) state_q <= StLoad;
            else                 state_q <= StDiv;
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  assign dstart = (state_q == StDiv) && (wait_q == 2'd0) && (det_q != '0);

  // element store and serial weighting datapath
  always_ff @(posedge clk_i) begin
    if (accept) mat_q[cnt_q] <= element_i;
    if (state_q == StWait && wait_q == '0) begin
      minor_q <= acc;
      w_q     <= wel;
      part_q  <= '0;
    end
    if (state_q == StCof) begin
      // two's complement serial multiply, msb weight negative
      if (w_q[sh_q[4:0]]) begin
        if (sh_q == 6'd31) part_q <= part_q - (minor_q <<< sh_q[4:0]);
        else               part_q <= part_q + (minor_q <<< sh_q[4:0]);
      end
      if (sh_q == 6'd31) begin
        logic signed [DW-1:0] t;
        logic signed [DW-1:0] s;
        t = w_q[31] ? (part_q - (minor_q <<< 5'd31)) : part_q;
        s = (step_q == 3'd2) ? t : ((step_q == 3'd4) ? (sum_q - t) : (sum_q + t));
        sum_q <= s;
        if (step_q == 3'd6)
          cofs_q[cof_q] <= (ci[0] ^ cj[0]) ? DW'(-s) : s;
      end
    end
    if (state_q == StDet) begin
      if (sh_q == '0) begin
        part_q <= '0;
        w_q    <= mat_q[{2'd0, step_q[1:0]}];
        if (step_q == '0) det_q <= '0;
      end else begin
        if (w_q[sh_q[4:0] - 5'd1]) begin
          part_q <= part_q + (cofs_q[{2'd0, step_q[1:0]}] <<< (sh_q[4:0] - 5'd1));
        end
      end
      if (sh_q == 6'd31) begin
        logic signed [DW-1:0] pt;
        pt = part_q;
        if (w_q[30]) pt = pt + (cofs_q[{2'd0, step_q[1:0]}] <<< 5'd30);
        if (w_q[31]) pt = pt - (cofs_q[{2'd0, step_q[1:0]}] <<< 5'd31);
        det_q <= det_q + pt;
      end
    end
    if (state_q == StDiv && !dbusy && wait_q == 2'd1) begin
      logic hi;
      hi = |quo[m4inv_pkg::DivW-1:32];
      singular_o <= (det_q == '0);
      last_o     <= (oidx_q == 4'd15);
      if (det_q == '0) inv_element_o <= '0;
      else if (!qneg)
        inv_element_o <= (hi || quo[31]) ? 32'h7FFFFFFF : quo[31:0];
      else
        inv_element_o <= (hi || quo[31:0] > 32'h80000000) ? 32'h80000000
                                                          : 32'(-quo[31:0]);
    end
  end

endmodule

FILE: rtl/m4inv_mac.sv
// shared multiply-accumulate unit: 32x32 multiply then wide load/add/sub into an accumulator
module m4inv_mac (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            mul_valid_i,
  input  m4inv_pkg::mul_op_e              op_i,
  input  logic signed [m4inv_pkg::ElemW-1:0] a_i,
  input  logic signed [m4inv_pkg::ElemW-1:0] b_i,
  output logic signed [m4inv_pkg::DetW-1:0]  acc_o
);
  logic signed [63:0] prod_q;
  logic               pv_q;
  m4inv_pkg::mul_op_e pop_q;
  logic signed [m4inv_pkg::DetW-1:0] acc_q;

  // product register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      pop_q <= m4inv_pkg::MulOpNop;
    end else begin
      pv_q  <= mul_valid_i;
      pop_q <= op_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  // accumulate
  always_ff @(posedge clk_i) begin
    if (pv_q) begin
      case (pop_q)
        m4inv_pkg::MulOpSet: acc_q <= m4inv_pkg::DetW'(prod_q);
        m4inv_pkg::MulOpAdd: acc_q <= acc_q + m4inv_pkg::DetW'(prod_q);
        m4inv_pkg::MulOpSub: acc_q <= acc_q - m4inv_pkg::DetW'(prod_q);
        default:             acc_q <= acc_q;
      endcase
    end
  end

  assign acc_o = acc_q;
endmodule

FILE: rtl/m4inv_div.sv
// restoring divider, one quotient bit per cycle
module m4inv_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [m4inv_pkg::DivW-1:0]     num_i,
  input  logic [m4inv_pkg::DetW-1:0]     den_i,
  output logic                           busy_o,
  output logic [m4inv_pkg::DivW-1:0]     quo_o
);
  localparam int unsigned RemW = m4inv_pkg::DetW + 1;
  logic [m4inv_pkg::DivW-1:0]    n_q;
  logic [RemW-1:0]               r_q;
  logic [m4inv_pkg::DetW-1:0]    d_q;
  logic [m4inv_pkg::DivCntW-1:0] cnt_q;
  logic                          busy_q;
  logic [RemW-1:0]               shl;
  logic [RemW-1:0]               dif;

  assign shl = {r_q[RemW-2:0], n_q[m4inv_pkg::DivW-1]};
  assign dif = shl - {1'b0, d_q};

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= m4inv_pkg::DivCntW'(m4inv_pkg::DivW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - m4inv_pkg::DivCntW'(1);
      if (cnt_q == '0) busy_q <= 1'b0;
    end
  end

  // datapath: numerator register shifts out and collects quotient bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= num_i;
      r_q <= '0;
      d_q <= den_i;
    end else if (busy_q) begin
      if (!dif[RemW-1]) begin
        r_q <= dif;
        n_q <= {n_q[m4inv_pkg::DivW-2:0], 1'b1};
      end else begin
        r_q <= shl;
        n_q <= {n_q[m4inv_pkg::DivW-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = n_q;
endmodule

FILE: tb/sv/matrix4x4_inverse_checker.sv
// checker for the 4x4 matrix inverse core: watches both channels, predicts and compares
module matrix4x4_inverse_checker #(
  parameter int unsigned FRAC_BITS = m4inv_pkg::FracBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               element_valid_i,
  input  logic               element_stall_i,
  input  logic signed [31:0] element_i,
  input  logic               inv_valid_i,
  input  logic               inv_stall_i,
  input  logic signed [31:0] inv_element_i,
  input  logic               singular_i,
  input  logic               last_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 matrices_o,
  output int                 results_o,
  output int                 singular_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] acc_t;

  typedef struct {
    logic [31:0] value;
    logic        singular;
    logic        last;
  } inv_result_t;

  acc_t        loaded [16];
  int          load_slot;
  inv_result_t inverse_q [$];

  // 3x3 minor of the loaded matrix, signed by checkerboard position
  function automatic acc_t cofactor(input int row, input int col);
    acc_t b [9];
    acc_t s;
    int   k;
    k = 0;
    for (int i = 0; i < 4; i++) begin
      if (i == row) continue;
      for (int j = 0; j < 4; j++) begin
        if (j == col) continue;
        b[k] = loaded[i * 4 + j];
        k++;
      end
    end
    s = b[0] * (b[4] * b[8] - b[5] * b[7])
      - b[1] * (b[3] * b[8] - b[5] * b[6])
      + b[2] * (b[3] * b[7] - b[4] * b[6]);
    return ((row + col) % 2 == 1) ? -s : s;
  endfunction

  // full inverse of the loaded matrix, queued in row-major order
  function automatic void predict_inverse();
    acc_t        cof [16];
    acc_t        det;
    logic [255:0] dmag, cmag, quot;
    logic        dneg, cneg, neg;
    inv_result_t r;
    det = '0;
    for (int i = 0; i < 16; i++) cof[i] = cofactor(i / 4, i % 4);
    for (int i = 0; i < 4; i++) det = det + cof[i] * loaded[i];
    dneg = det[255];
    dmag = dneg ? -det : det;
    for (int k = 0; k < 16; k++) begin
      r.value = '0;
      r.singular = 1'b1;
      r.last = (k == 15);
      if (det != 0) begin
        cmag = cof[(k % 4) * 4 + k / 4];
        cneg = cmag[255];
        if (cneg) cmag = -cmag;
        quot = (cmag << (2 * FRAC_BITS)) / dmag;
        neg = cneg ^ dneg;
        if (!neg)
          r.value = (quot > 256'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot[31:0];
        else
          r.value = (quot > 256'h8000_0000) ? 32'h8000_0000 : 32'(-quot[31:0]);
        r.singular = 1'b0;
      end
      inverse_q.push_back(r);
    end
  endfunction

  // element loading and result comparison
  always @(posedge clk_i or negedge rst_ni) begin
    inv_result_t e;
    if (!rst_ni) begin
      load_slot <= 0;
      inverse_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
      matrices_o <= 0;
      results_o <= 0;
      singular_seen_o <= 0;
    end else begin
      if (element_valid_i && !element_stall_i) begin
        loaded[load_slot] = acc_t'(element_i);
        if (load_slot == 15) begin
          predict_inverse();
          matrices_o <= matrices_o + 1;
        end
        load_slot <= (load_slot + 1) % 16;
      end
      if (inv_valid_i && !inv_stall_i) begin
        results_o <= results_o + 1;
        if (singular_i) singular_seen_o <= singular_seen_o + 1;
        if (inverse_q.size() == 0) begin
          $display("%0t: unexpected transaction inv=%h singular=%b last=%b",
                   $realtime, inv_element_i, singular_i, last_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = inverse_q.pop_front();
          if (inv_element_i !== e.value || singular_i !== e.singular ||
              last_i !== e.last) begin
            $display("%0t: expected inv=%h sing=%b last=%b, got inv=%h sing=%b last=%b",
                     $realtime, e.value, e.singular, e.last,
                     inv_element_i, singular_i, last_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= inverse_q.size();
    end
  end

endmodule

FILE: tb/sv/tb.sv
// testbench top for the 4x4 matrix inverse core: clock, reset, stimulus and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TailCycles = 200;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               element_valid_i = 1'b0;
  logic               element_stall_o;
  logic signed [31:0] element_i = '0;
  logic               inv_valid_o;
  logic               inv_stall_i = 1'b0;
  logic signed [31:0] inv_element_o;
  logic               singular_o;
  logic               last_o;

  int fail_count, pending, matrices, results, singular_seen;
  bit busy_sender;
  bit pressure_done = 1'b0;

  matrix4x4_inverse_core uut (.*);

  matrix4x4_inverse_checker chk (
    .clk_i, .rst_ni, .element_valid_i, .element_stall_i(element_stall_o), .element_i,
    .inv_valid_i(inv_valid_o), .inv_stall_i, .inv_element_i(inv_element_o),
    .singular_i(singular_o), .last_i(last_o), .fail_count_o(fail_count),
    .pending_o(pending), .matrices_o(matrices), .results_o(results),
    .singular_seen_o(singular_seen)
  );

  always #4 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // offer one element and hold it until the transaction completes
  task automatic send_element(input logic [31:0] d, input bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      element_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    element_valid_i <= 1'b1;
    element_i <= d;
    do @(posedge clk_i); while (element_stall_o);
  endtask

  task automatic send_matrix(input logic [31:0] m [16], input bit no_gaps);
    for (int i = 0; i < 16; i++) send_element(m[i], no_gaps);
  endtask

  // random matrix in one of several styles
  task automatic make_matrix(output logic [31:0] m [16]);
    int style;
    style = $urandom_range(9);
    for (int i = 0; i < 16; i++) begin
      case (style)
        0, 1:    m[i] = $urandom;
        2, 3, 4: m[i] = (i % 5 == 0) ? 32'($urandom_range(8, 2)) << 16
                                     : 32'($signed($urandom_range(65535)) - 32768);
        5, 6:    m[i] = 32'($signed($urandom_range(16)) - 8) << 16;
        7:       m[i] = 32'($signed($urandom_range(2000)) - 1000);
        default: m[i] = $urandom;
      endcase
    end
    // duplicated row makes it singular
    if (style == 9)
      for (int j = 0; j < 4; j++) m[12 + j] = m[4 + j];
  endtask

  // receiver: random holds, one long hold once four matrices are loaded while the sender is busy
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!pressure_done && matrices >= 4 && busy_sender) begin
        pressure_done = 1'b1;
        inv_stall_i <= 1'b1;
        repeat (4000) @(posedge clk_i);
      end else begin
        gap = pick_gap();
        inv_stall_i <= (gap > 0);
        if (gap > 1) repeat (gap - 1) @(posedge clk_i);
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic [31:0] m [16];
    bit no_gaps;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    busy_sender = 1'b1;
    @(posedge clk_i);

    // directed: saturation both ways and field extremes on the diagonal
    for (int i = 0; i < 16; i++) m[i] = '0;
    m[0] = 32'h0000_0001;
    m[5] = 32'hFFFF_FFFF;
    m[10] = 32'h7FFF_FFFF;
    m[15] = 32'h8000_0000;
    send_matrix(m, 1'b0);
    // directed: all-zero matrix is singular
    for (int i = 0; i < 16; i++) m[i] = '0;
    send_matrix(m, 1'b1);

    // random matrices, a few sent back to back
    for (int n = 0; n < 10; n++) begin
      make_matrix(m);
      no_gaps = ($urandom_range(3) == 0);
      send_matrix(m, no_gaps);
    end
    element_valid_i <= 1'b0;
    busy_sender = 1'b0;

    // let the checker take in the last element before watching its queue
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d matrices, %0d results checked, %0d singular results",
             matrices, results, singular_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: files.f
rtl/m4inv_pkg.sv
rtl/m4inv_mac.sv
rtl/m4inv_div.sv
rtl/matrix4x4_inverse_core.sv
tb/sv/matrix4x4_inverse_checker.sv
tb/sv/tb.sv
